FILE: rtl/tlwt_pkg.sv
package tlwt_pkg;

    localparam int TLWT_SEQ_BITS    = 15;
    localparam int TLWT_TIMER_BITS  = 9;
    localparam int TLWT_MAX_RESULTS = 3;
    localparam int TLWT_CFG_IDX_W   = 3;
    localparam int TLWT_CFG_DATA_W  = 15;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_RX_FRAME   = 3'd1,
        KIND_SEND_I     = 3'd2,
        KIND_STARTDT    = 3'd3,
        KIND_STOPDT     = 3'd4,
        KIND_TESTFR     = 3'd5,
        KIND_CONNECT    = 3'd6,
        KIND_DISCONNECT = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        FK_NONE        = 3'd0,
        FK_I           = 3'd1,
        FK_S           = 3'd2,
        FK_STARTDT_ACT = 3'd3,
        FK_STOPDT_CON  = 3'd4,
        FK_TESTFR_ACT  = 3'd5,
        FK_TESTFR_CON  = 3'd6,
        FK_STOPDT_ACT  = 3'd7
    } frame_kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_LENGTH  = 3'd1,
        ST_UNKNOWN_U   = 3'd2,
        ST_SEQ_MISMATCH = 3'd3,
        ST_BAD_ACK     = 3'd4,
        ST_WINDOW_FULL = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CFG_T1_RELOAD      = 3'd0,
        CFG_T2_RELOAD      = 3'd1,
        CFG_T3_RELOAD      = 3'd2,
        CFG_WINDOW_K       = 3'd3,
        CFG_WINDOW_W       = 3'd4,
        CFG_CHECK_SEQUENCE = 3'd5,
        CFG_AUTO_REPLY     = 3'd6
    } cfg_index_t;

    localparam logic [15:0] U_STARTDT_ACT = 16'h0007;
    localparam logic [15:0] U_STARTDT_CON = 16'h000B;
    localparam logic [15:0] U_STOPDT_ACT  = 16'h0013;
    localparam logic [15:0] U_STOPDT_CON  = 16'h0023;
    localparam logic [15:0] U_TESTFR_ACT  = 16'h0043;
    localparam logic [15:0] U_TESTFR_CON  = 16'h0083;
    localparam logic [15:0] S_CODE        = 16'h0001;

    localparam logic [7:0] APDU_LEN_US = 8'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  frame_len;
        logic [15:0] rx_first_word;
        logic [15:0] rx_second_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [15:0] tx_first_word;
        logic [15:0] tx_second_word;
        logic [2:0]  status;
        logic        drop_link;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic [7:0]                 t1_reload;
        logic [7:0]                 t2_reload;
        logic [7:0]                 t3_reload;
        logic [TLWT_SEQ_BITS-1:0]   window_k;
        logic [TLWT_SEQ_BITS-1:0]   window_w;
        logic                       check_sequence;
        logic                       auto_reply;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } entry_t;

    typedef struct packed {
        entry_t [TLWT_MAX_RESULTS-1:0] entries;
        logic [1:0]                    count;
        logic [2:0]                    status;
        logic                          drop_link;
    } bundle_t;

endpackage

FILE: rtl/tlwt_cfg_regs.sv
module tlwt_cfg_regs
    import tlwt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [TLWT_CFG_IDX_W-1:0]  cfg_index,
    input  logic [TLWT_CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_T1_RELOAD:      cfg_next.t1_reload      = cfg_data[7:0];
                CFG_T2_RELOAD:      cfg_next.t2_reload      = cfg_data[7:0];
                CFG_T3_RELOAD:      cfg_next.t3_reload      = cfg_data[7:0];
                CFG_WINDOW_K:       cfg_next.window_k       = cfg_data[TLWT_SEQ_BITS-1:0];
                CFG_WINDOW_W:       cfg_next.window_w       = cfg_data[TLWT_SEQ_BITS-1:0];
                CFG_CHECK_SEQUENCE: cfg_next.check_sequence = cfg_data[0];
                CFG_AUTO_REPLY:     cfg_next.auto_reply     = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.t1_reload      <= 8'd15;
            cfg_reg.t2_reload      <= 8'd10;
            cfg_reg.t3_reload      <= 8'd20;
            cfg_reg.window_k       <= TLWT_SEQ_BITS'(12);
            cfg_reg.window_w       <= TLWT_SEQ_BITS'(8);
            cfg_reg.check_sequence <= 1'b1;
            cfg_reg.auto_reply     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tlwt_core.sv
module tlwt_core
    import tlwt_pkg::*;
#(
    parameter int TIMER_BITS = TLWT_TIMER_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     process,
    input  in_item_t item,
    input  cfg_t     cfg,
    output bundle_t  bundle
);

    localparam int TMAX = (2 ** (TIMER_BITS - 1)) - 1;
    localparam int SB   = TLWT_SEQ_BITS;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [SB-1:0]         seq_t;

    localparam timer_t TIMER_OFF = '1;

    seq_t   send_seq_reg, send_seq_next;
    seq_t   recv_seq_reg, recv_seq_next;
    seq_t   unacked_reg, unacked_next;
    seq_t   received_reg, received_next;
    logic   may_send_reg, may_send_next;
    logic   link_up_reg, link_up_next;
    timer_t confirm_reg, confirm_next;
    timer_t ack_reg, ack_next;
    timer_t idle_reg, idle_next;

    seq_t   nr;
    seq_t   ns;
    seq_t   ack_diff;
    seq_t   rc_inc;
    seq_t   unacked_inc;
    logic   ack_ok;
    timer_t t_dec;
    logic [1:0] n;
    bundle_t bundle_c;

    function automatic timer_t reload_of(input logic [7:0] v);
        if (int'(v) > TMAX)
            return timer_t'(TMAX);
        else
            return timer_t'(v);
    endfunction

    function automatic logic positive(input timer_t t);
        return !t[TIMER_BITS-1] && (t != '0);
    endfunction

    function automatic entry_t mk_entry(input frame_kind_t fk, input logic [15:0] w1,
                                        input logic [15:0] w2);
        entry_t e;
        e.frame_kind  = fk;
        e.first_word  = w1;
        e.second_word = w2;
        return e;
    endfunction

    assign nr       = item.rx_second_word[SB:1];
    assign ns       = item.rx_first_word[SB:1];
    assign ack_ok   = !(send_seq_reg < nr);
    assign ack_diff = send_seq_reg - nr;

    always_comb
    begin
        send_seq_next = send_seq_reg;
        recv_seq_next = recv_seq_reg;
        unacked_next  = unacked_reg;
        received_next = received_reg;
        may_send_next = may_send_reg;
        link_up_next  = link_up_reg;
        confirm_next  = confirm_reg;
        ack_next      = ack_reg;
        idle_next     = idle_reg;
        bundle_c      = '0;
        n             = 2'd0;
        t_dec         = '0;
        rc_inc        = received_reg + SB'(1);
        unacked_inc   = unacked_reg + SB'(1);

        case (item.kind)
            KIND_TICK:
            begin
                if (link_up_reg)
                begin
                    if (positive(confirm_reg))
                    begin
                        t_dec = confirm_reg - timer_t'(1);
                        if (t_dec == '0)
                        begin
                            bundle_c.entries[n] = mk_entry(FK_STARTDT_ACT, U_STARTDT_ACT, 16'd0);
                            n = n + 2'd1;
                            confirm_next = reload_of(cfg.t1_reload);
                        end
                        else
                        begin
                            confirm_next = t_dec;
                        end
                    end
                    if (positive(ack_reg))
                    begin
                        t_dec = ack_reg - timer_t'(1);
                        if (t_dec == '0)
                        begin
                            bundle_c.entries[n] = mk_entry(FK_S, S_CODE, {recv_seq_reg, 1'b0});
                            n = n + 2'd1;
                            ack_next = TIMER_OFF;
                        end
                        else
                        begin
                            ack_next = t_dec;
                        end
                    end
                    if (positive(idle_reg))
                    begin
                        t_dec = idle_reg - timer_t'(1);
                        idle_next = t_dec;
                        if (t_dec == '0)
                        begin
                            bundle_c.entries[n] = mk_entry(FK_TESTFR_ACT, U_TESTFR_ACT, 16'd0);
                            n = n + 2'd1;
                        end
                    end
                end
            end
            KIND_RX_FRAME:
            begin
                if (item.frame_len < APDU_LEN_US)
                begin
                    bundle_c.status = ST_BAD_LENGTH;
                end
                else if (item.frame_len == APDU_LEN_US)
                begin
                    case (item.rx_first_word)
                        U_STARTDT_CON: confirm_next = TIMER_OFF;
                        U_STOPDT_ACT:
                        begin
                            if (cfg.auto_reply)
                            begin
                                bundle_c.entries[n] = mk_entry(FK_STOPDT_CON, U_STOPDT_CON, 16'd0);
                                n = n + 2'd1;
                            end
                        end
                        U_STOPDT_CON: ;
                        U_TESTFR_ACT:
                        begin
                            if (cfg.auto_reply)
                            begin
                                bundle_c.entries[n] = mk_entry(FK_TESTFR_CON, U_TESTFR_CON, 16'd0);
                                n = n + 2'd1;
                            end
                        end
                        U_TESTFR_CON: ;
                        S_CODE:
                        begin
                            if (ack_ok)
                            begin
                                unacked_next = ack_diff;
                                if (ack_diff < cfg.window_k)
                                    may_send_next = 1'b1;
                            end
                            else
                            begin
                                bundle_c.status = ST_BAD_ACK;
                            end
                        end
                        default: bundle_c.status = ST_UNKNOWN_U;
                    endcase
                end
                else
                begin
                    if ((ns != recv_seq_reg) && cfg.check_sequence)
                    begin
                        bundle_c.status    = ST_SEQ_MISMATCH;
                        bundle_c.drop_link = 1'b1;
                    end
                    else
                    begin
                        if (ns != recv_seq_reg)
                            bundle_c.status = ST_SEQ_MISMATCH;
                        else
                            recv_seq_next = recv_seq_reg + SB'(1);
                        if (!ack_ok)
                        begin
                            bundle_c.status = ST_BAD_ACK;
                        end
                        else
                        begin
                            unacked_next = ack_diff;
                            if (ack_diff < cfg.window_k)
                                may_send_next = 1'b1;
                            if (ack_reg[TIMER_BITS-1])
                            begin
                                ack_next = reload_of(cfg.t2_reload);
                            end
                            else if (ack_reg == '0)
                            begin
                                ack_next = TIMER_OFF;
                                bundle_c.entries[n] = mk_entry(FK_S, S_CODE,
                                                               {recv_seq_next, 1'b0});
                                n = n + 2'd1;
                            end
                            else
                            begin
                                ack_next = ack_reg - timer_t'(1);
                            end
                            idle_next = reload_of(cfg.t3_reload);
                            if (cfg.auto_reply)
                            begin
                                if (rc_inc == cfg.window_w)
                                begin
                                    bundle_c.entries[n] = mk_entry(FK_S, S_CODE,
                                                                   {recv_seq_next, 1'b0});
                                    n = n + 2'd1;
                                    received_next = '0;
                                end
                                else
                                begin
                                    received_next = rc_inc;
                                end
                            end
                        end
                    end
                end
            end
            KIND_SEND_I:
            begin
                if (!may_send_reg)
                begin
                    bundle_c.status = ST_WINDOW_FULL;
                end
                else
                begin
                    bundle_c.entries[n] = mk_entry(FK_I, {send_seq_reg, 1'b0},
                                                   {recv_seq_reg, 1'b0});
                    n = n + 2'd1;
                    send_seq_next = send_seq_reg + SB'(1);
                    unacked_next  = unacked_inc;
                    if (unacked_inc == cfg.window_k)
                        may_send_next = 1'b0;
                end
            end
            KIND_STARTDT:
            begin
                bundle_c.entries[n] = mk_entry(FK_STARTDT_ACT, U_STARTDT_ACT, 16'd0);
                n = n + 2'd1;
                confirm_next = reload_of(cfg.t1_reload);
            end
            KIND_STOPDT:
            begin
                bundle_c.entries[n] = mk_entry(FK_STOPDT_ACT, U_STOPDT_ACT, 16'd0);
                n = n + 2'd1;
            end
            KIND_TESTFR:
            begin
                bundle_c.entries[n] = mk_entry(FK_TESTFR_ACT, U_TESTFR_ACT, 16'd0);
                n = n + 2'd1;
            end
            KIND_CONNECT:
            begin
                send_seq_next = '0;
                recv_seq_next = '0;
                link_up_next  = 1'b1;
            end
            default:
            begin
                link_up_next  = 1'b0;
                confirm_next  = TIMER_OFF;
                ack_next      = TIMER_OFF;
                send_seq_next = '0;
                recv_seq_next = '0;
                received_next = '0;
                unacked_next  = '0;
                may_send_next = 1'b1;
            end
        endcase

        // no frame sent: a single empty transaction
        bundle_c.count = (n == 2'd0) ? 2'd1 : n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_seq_reg <= '0;
            recv_seq_reg <= '0;
            unacked_reg  <= '0;
            received_reg <= '0;
            may_send_reg <= 1'b1;
            link_up_reg  <= 1'b0;
            confirm_reg  <= TIMER_OFF;
            ack_reg      <= TIMER_OFF;
            idle_reg     <= TIMER_OFF;
        end
        else if (process)
        begin
            send_seq_reg <= send_seq_next;
            recv_seq_reg <= recv_seq_next;
            unacked_reg  <= unacked_next;
            received_reg <= received_next;
            may_send_reg <= may_send_next;
            link_up_reg  <= link_up_next;
            confirm_reg  <= confirm_next;
            ack_reg      <= ack_next;
            idle_reg     <= idle_next;
        end
    end

    assign bundle = bundle_c;

endmodule

FILE: rtl/tlwt_out_buf.sv
module tlwt_out_buf
    import tlwt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  bundle_t   bundle,
    output logic      free,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    bundle_t    bundle_reg;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       is_last;
    logic       take;
    entry_t     head;

    assign is_last = (idx_reg == (bundle_reg.count - 2'd1));
    assign take    = valid_reg && !result_stall;
    assign free    = !valid_reg || (take && is_last);
    assign head    = bundle_reg.entries[idx_reg];

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            if (is_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bundle_reg <= bundle;
    end

    assign result_valid          = valid_reg;
    assign result.frame_kind     = head.frame_kind;
    assign result.tx_first_word  = head.first_word;
    assign result.tx_second_word = head.second_word;
    assign result.status         = bundle_reg.status;
    assign result.drop_link      = bundle_reg.drop_link;
    assign result.last_result    = is_last;

endmodule

FILE: rtl/telecontrol_link_window_timers_unit.sv
// Path: an accepted item is held in the input register, then its result
// bundle in the result buffer. Throughput: one item per cycle while each item
// gives one result and result_stall stays low; an item that gives n results
// (n up to 3) holds the result buffer while they leave on the single output port.
// Reset: sequence numbers and counts cleared, send allowed, link down, t1/t2/t3 off.
module telecontrol_link_window_timers_unit
    import tlwt_pkg::*;
#(
    parameter int TIMER_BITS = TLWT_TIMER_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  in_item_t                   item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output out_item_t                  result,
    input  logic                       cfg_we,
    input  logic [TLWT_CFG_IDX_W-1:0]  cfg_index,
    input  logic [TLWT_CFG_DATA_W-1:0] cfg_data
);

    in_item_t item_reg;
    logic     item_valid_reg, item_valid_next;
    logic     buf_free;
    logic     process;
    logic     take_in;
    cfg_t     cfg;
    bundle_t  bundle;

    assign process    = item_valid_reg && buf_free;
    assign item_stall = item_valid_reg && !buf_free;
    assign take_in    = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take_in)
            item_valid_next = 1'b1;
        else if (process)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            item_reg <= item;
    end

    tlwt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlwt_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .process (process),
        .item    (item_reg),
        .cfg     (cfg),
        .bundle  (bundle)
    );

    tlwt_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (process),
        .bundle       (bundle),
        .free         (buf_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import tlwt_pkg::*;

    localparam int TMR_MAX = (1 << (TLWT_TIMER_BITS - 1)) - 1;
    localparam logic [15:0] U_RX_CODES [0:5] = '{U_STARTDT_CON, U_STOPDT_ACT, U_STOPDT_CON,
                                                 U_TESTFR_ACT, U_TESTFR_CON, S_CODE};

    class apci_link_tracker;
        logic [7:0]  t1_rl, t2_rl, t3_rl;
        logic [14:0] win_k, win_w;
        logic        check_seq, auto_rep;

        logic [14:0] send_seq, recv_seq, unacked, rcv_cnt;
        logic        may_send, link_up;
        int          confirm_tmr, ack_tmr, idle_tmr;

        out_item_t   item_frames[$];
        out_item_t   expected_frames[$];
        int          errors;
        int          n_items;
        int          n_checked;
        int          status_seen[8];

        function new();
            t1_rl = 8'd15;
            t2_rl = 8'd10;
            t3_rl = 8'd20;
            win_k = 15'd12;
            win_w = 15'd8;
            check_seq = 1'b1;
            auto_rep = 1'b1;
            send_seq = '0;
            recv_seq = '0;
            unacked = '0;
            rcv_cnt = '0;
            may_send = 1'b1;
            link_up = 1'b0;
            confirm_tmr = -1;
            ack_tmr = -1;
            idle_tmr = -1;
            errors = 0;
            n_items = 0;
            n_checked = 0;
        endfunction

        function void set_cfg(cfg_index_t idx, logic [14:0] v);
            case (idx)
                CFG_T1_RELOAD:      t1_rl = v[7:0];
                CFG_T2_RELOAD:      t2_rl = v[7:0];
                CFG_T3_RELOAD:      t3_rl = v[7:0];
                CFG_WINDOW_K:       win_k = v;
                CFG_WINDOW_W:       win_w = v;
                CFG_CHECK_SEQUENCE: check_seq = v[0];
                CFG_AUTO_REPLY:     auto_rep = v[0];
                default: ;
            endcase
        endfunction

        function int reload_of(logic [7:0] v);
            return (int'(v) > TMR_MAX) ? TMR_MAX : int'(v);
        endfunction

        function void add_frame(frame_kind_t fk, logic [15:0] w1, logic [15:0] w2);
            out_item_t r;
            r = '0;
            r.frame_kind = fk;
            r.tx_first_word = w1;
            r.tx_second_word = w2;
            if (item_frames.size() < TLWT_MAX_RESULTS)
                item_frames.push_back(r);
        endfunction

        function void add_s();
            add_frame(FK_S, S_CODE, {recv_seq, 1'b0});
        endfunction

        function bit take_ack(logic [15:0] w2);
            logic [14:0] nr;
            nr = w2[15:1];
            if (send_seq < nr)
                return 1'b0;
            unacked = send_seq - nr;
            if (unacked < win_k)
                may_send = 1'b1;
            return 1'b1;
        endfunction

        function void take_info(logic [15:0] w1, logic [15:0] w2,
                                inout logic [2:0] st, inout logic drop);
            if (w1[15:1] != recv_seq) begin
                st = ST_SEQ_MISMATCH;
                if (check_seq) begin
                    drop = 1'b1;
                    return;
                end
            end
            else
                recv_seq = recv_seq + 15'd1;
            if (!take_ack(w2)) begin
                st = ST_BAD_ACK;
                return;
            end
            if (ack_tmr < 0)
                ack_tmr = reload_of(t2_rl);
            else if (ack_tmr == 0) begin
                ack_tmr = -1;
                add_s();
            end
            else
                ack_tmr--;
            idle_tmr = reload_of(t3_rl);
            if (auto_rep) begin
                rcv_cnt = rcv_cnt + 15'd1;
                if (rcv_cnt == win_w) begin
                    add_s();
                    rcv_cnt = '0;
                end
            end
        endfunction

        function void do_tick();
            if (!link_up)
                return;
            if (confirm_tmr > 0) begin
                confirm_tmr--;
                if (confirm_tmr == 0) begin
                    add_frame(FK_STARTDT_ACT, U_STARTDT_ACT, 16'h0000);
                    confirm_tmr = reload_of(t1_rl);
                end
            end
            if (ack_tmr > 0) begin
                ack_tmr--;
                if (ack_tmr == 0) begin
                    add_s();
                    ack_tmr = -1;
                end
            end
            if (idle_tmr > 0) begin
                idle_tmr--;
                if (idle_tmr == 0)
                    add_frame(FK_TESTFR_ACT, U_TESTFR_ACT, 16'h0000);
            end
        endfunction

        function void note_item(in_item_t it);
            logic [2:0] st;
            logic       drop;
            out_item_t  r;
            st = ST_OK;
            drop = 1'b0;
            item_frames.delete();
            n_items++;
            case (kind_t'(it.kind))
                KIND_TICK: do_tick();
                KIND_RX_FRAME: begin
                    if (it.frame_len < APDU_LEN_US)
                        st = ST_BAD_LENGTH;
                    else if (it.frame_len == APDU_LEN_US) begin
                        case (it.rx_first_word)
                            U_STARTDT_CON: confirm_tmr = -1;
                            U_STOPDT_ACT:
                                if (auto_rep)
                                    add_frame(FK_STOPDT_CON, U_STOPDT_CON, 16'h0000);
                            U_TESTFR_ACT:
                                if (auto_rep)
                                    add_frame(FK_TESTFR_CON, U_TESTFR_CON, 16'h0000);
                            U_STOPDT_CON, U_TESTFR_CON: ;
                            S_CODE:
                                if (!take_ack(it.rx_second_word))
                                    st = ST_BAD_ACK;
                            default: st = ST_UNKNOWN_U;
                        endcase
                    end
                    else
                        take_info(it.rx_first_word, it.rx_second_word, st, drop);
                end
                KIND_SEND_I: begin
                    if (!may_send)
                        st = ST_WINDOW_FULL;
                    else begin
                        add_frame(FK_I, {send_seq, 1'b0}, {recv_seq, 1'b0});
                        send_seq = send_seq + 15'd1;
                        unacked = unacked + 15'd1;
                        if (unacked == win_k)
                            may_send = 1'b0;
                    end
                end
                KIND_STARTDT: begin
                    add_frame(FK_STARTDT_ACT, U_STARTDT_ACT, 16'h0000);
                    confirm_tmr = reload_of(t1_rl);
                end
                KIND_STOPDT: add_frame(FK_STOPDT_ACT, U_STOPDT_ACT, 16'h0000);
                KIND_TESTFR: add_frame(FK_TESTFR_ACT, U_TESTFR_ACT, 16'h0000);
                KIND_CONNECT: begin
                    send_seq = '0;
                    recv_seq = '0;
                    link_up = 1'b1;
                end
                default: begin
                    link_up = 1'b0;
                    confirm_tmr = -1;
                    ack_tmr = -1;
                    send_seq = '0;
                    recv_seq = '0;
                    rcv_cnt = '0;
                    unacked = '0;
                    may_send = 1'b1;
                end
            endcase
            if (item_frames.size() == 0)
                add_frame(FK_NONE, 16'h0000, 16'h0000);
            status_seen[st]++;
            foreach (item_frames[i]) begin
                r = item_frames[i];
                r.status = st;
                r.drop_link = drop;
                r.last_result = (i == item_frames.size() - 1);
                expected_frames.push_back(r);
            end
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, got %h", $time, got);
                return;
            end
            want = expected_frames.pop_front();
            n_checked++;
            cmp_field("frame_kind", want.frame_kind, got.frame_kind);
            cmp_field("tx_first_word", want.tx_first_word, got.tx_first_word);
            cmp_field("tx_second_word", want.tx_second_word, got.tx_second_word);
            cmp_field("status", want.status, got.status);
            cmp_field("drop_link", want.drop_link, got.drop_link);
            cmp_field("last_result", want.last_result, got.last_result);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    in_item_t                   item = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    out_item_t                  result;
    logic                       cfg_we = 1'b0;
    logic [TLWT_CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TLWT_CFG_DATA_W-1:0] cfg_data = '0;

    apci_link_tracker trk = new();
    bit quiet_run = 1'b0;
    int stall_left = 0;
    int n_settings = 0;

    telecontrol_link_window_timers_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(negedge clk) begin
        if (stall_left > 0) begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else begin
            result_stall <= 1'b0;
            if (!quiet_run && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall)
            trk.check_result(result);
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", trk.pending());
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [14:0] pick_nr();
        int s;
        int u;
        s = trk.send_seq;
        u = trk.unacked;
        if (u > s)
            u = s;
        return 15'(s - $urandom_range(0, u));
    endfunction

    function automatic in_item_t mk(kind_t k, logic [7:0] len, logic [15:0] w1,
                                    logic [15:0] w2);
        in_item_t it;
        it.kind = k;
        it.frame_len = len;
        it.rx_first_word = w1;
        it.rx_second_word = w2;
        return it;
    endfunction

    function automatic in_item_t make_item();
        in_item_t it;
        int       r;
        int       nr;
        it = mk(KIND_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
        r = $urandom_range(0, 99);
        if (!trk.link_up && r < 60) begin
            it.kind = KIND_CONNECT;
            return it;
        end
        if (r < 14) begin
            it.kind = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 1))
                it.frame_len = 8'($urandom_range(0, 4));
        end
        else if (r < 20) begin
            it.kind = KIND_RX_FRAME;
            it.frame_len = 8'($urandom_range(5, 255));
            it.rx_first_word = {trk.recv_seq + 15'($urandom_range(1, 32767)),
                                1'($urandom_range(0, 1))};
            it.rx_second_word = {pick_nr(), 1'($urandom_range(0, 1))};
        end
        else if (r < 24) begin
            nr = trk.send_seq + $urandom_range(1, 64);
            if (nr > 32767)
                nr = 32767;
            it.kind = KIND_RX_FRAME;
            it.rx_second_word = {15'(nr), 1'($urandom_range(0, 1))};
            if ($urandom_range(0, 1)) begin
                it.frame_len = APDU_LEN_US;
                it.rx_first_word = S_CODE;
            end
            else begin
                it.frame_len = 8'($urandom_range(5, 255));
                it.rx_first_word = {trk.recv_seq, 1'($urandom_range(0, 1))};
            end
        end
        else if (r < 44)
            it.kind = KIND_TICK;
        else if (r < 64) begin
            it.kind = KIND_RX_FRAME;
            it.frame_len = 8'($urandom_range(5, 255));
            it.rx_first_word = {trk.recv_seq, 1'($urandom_range(0, 1))};
            it.rx_second_word = {pick_nr(), 1'($urandom_range(0, 1))};
        end
        else if (r < 72) begin
            it.kind = KIND_RX_FRAME;
            it.frame_len = APDU_LEN_US;
            it.rx_first_word = S_CODE;
            it.rx_second_word = {pick_nr(), 1'($urandom_range(0, 1))};
        end
        else if (r < 78) begin
            it.kind = KIND_RX_FRAME;
            it.frame_len = APDU_LEN_US;
            it.rx_first_word = U_RX_CODES[$urandom_range(0, 5)];
        end
        else if (r < 92)
            it.kind = KIND_SEND_I;
        else if (r < 98)
            it.kind = 3'($urandom_range(KIND_STARTDT, KIND_TESTFR));
        else
            it.kind = KIND_DISCONNECT;
        return it;
    endfunction

    task automatic drive_item(in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        trk.note_item(it);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (trk.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_cfg(cfg_index_t idx, int unsigned v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 15'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        trk.set_cfg(idx, 15'(v));
    endtask

    task automatic apply_cfg(int unsigned t1, int unsigned t2, int unsigned t3,
                             int unsigned k, int unsigned w, int unsigned chk,
                             int unsigned auto_ans);
        write_cfg(CFG_T1_RELOAD, t1);
        write_cfg(CFG_T2_RELOAD, t2);
        write_cfg(CFG_T3_RELOAD, t3);
        write_cfg(CFG_WINDOW_K, k);
        write_cfg(CFG_WINDOW_W, w);
        write_cfg(CFG_CHECK_SEQUENCE, chk);
        write_cfg(CFG_AUTO_REPLY, auto_ans);
        n_settings++;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            quiet_run = ((i / 25) % 4 == 3);
            drive_item(make_item());
        end
        quiet_run = 1'b0;
        drain();
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default register values from reset
        drive_item(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_CONNECT, 8'hFF, 16'hFFFF, 16'hFFFF));
        drive_item(mk(KIND_STARTDT, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_TICK, 8'hFF, 16'hFFFF, 16'hFFFF));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, U_STARTDT_CON, 16'h0000));
        drive_item(mk(KIND_STOPDT, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_TESTFR, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, U_STOPDT_ACT, 16'h0000));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, U_TESTFR_ACT, 16'hFFFF));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, U_STOPDT_CON, 16'h0000));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, U_TESTFR_CON, 16'h0000));
        drive_item(mk(KIND_RX_FRAME, 8'h00, 16'hFFFF, 16'hFFFF));
        drive_item(mk(KIND_RX_FRAME, 8'h03, 16'h0000, 16'h0000));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, 16'hFFFF, 16'h0000));
        drive_item(mk(KIND_SEND_I, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_SEND_I, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, S_CODE, 16'h0004));
        drive_item(mk(KIND_RX_FRAME, APDU_LEN_US, S_CODE, 16'hFFFF));
        drive_item(mk(KIND_RX_FRAME, 8'hFF, 16'h0000, 16'h0005));
        drive_item(mk(KIND_RX_FRAME, 8'h05, 16'h0001, 16'h0000));
        drive_item(mk(KIND_RX_FRAME, 8'h05, 16'h0002, 16'hFFFE));
        drive_item(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_DISCONNECT, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
        drain();

        apply_cfg(1, 1, 1, 1, 1, 1, 1);
        drive_item(mk(KIND_SEND_I, 8'h00, 16'h0000, 16'h0000));
        drive_item(mk(KIND_SEND_I, 8'h00, 16'h0000, 16'h0000));
        run_random(80);

        apply_cfg(255, 255, 255, 32767, 32767, 0, 0);
        run_random(80);

        apply_cfg(2, 3, 4, 3, 2, 0, 1);
        run_random(85);

        apply_cfg($urandom_range(1, 20), $urandom_range(1, 12), $urandom_range(1, 25),
                  $urandom_range(1, 16), $urandom_range(1, 10), $urandom_range(0, 1),
                  $urandom_range(0, 1));
        run_random(85);

        apply_cfg(15, 10, 20, 12, 8, 1, 1);
        run_random(80);

        $display("Covered %0d input transactions and %0d checked results over %0d settings",
                 trk.n_items, trk.n_checked, n_settings + 1);
        $display("Status mix: ok %0d, bad length %0d, unknown U %0d, seq %0d, ack %0d, full %0d",
                 trk.status_seen[ST_OK], trk.status_seen[ST_BAD_LENGTH],
                 trk.status_seen[ST_UNKNOWN_U], trk.status_seen[ST_SEQ_MISMATCH],
                 trk.status_seen[ST_BAD_ACK], trk.status_seen[ST_WINDOW_FULL]);
        if (trk.errors == 0 && trk.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
